/* src/assert_macros.svh */
// assertion macros shared by the dma engine modules
// expects clk and rst_n in the scope of the module that uses them
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every edge out of reset
`define VBD_ASSERT(name, expr, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence must hold in the cycle after the antecedent
`define VBD_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* src/vbd_pkg.sv */
// types and constants of the video ram block dma engine
// used by vbd_core and vram_block_dma_engine; no dependencies
package vbd_pkg;

    // func codes
    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ  = 2'd1;
    localparam logic [1:0] FUNC_TICK  = 2'd2;

    // register select codes
    localparam logic [2:0] SEL_SRC_HI = 3'd0;
    localparam logic [2:0] SEL_SRC_LO = 3'd1;
    localparam logic [2:0] SEL_DST_HI = 3'd2;
    localparam logic [2:0] SEL_DST_LO = 3'd3;
    localparam logic [2:0] SEL_CTRL   = 3'd4;

    localparam int NUM_ADDR_REGS = 4;

    localparam logic [15:0] SRC_MASK    = 16'hFFF0;
    localparam logic [12:0] DST_MASK    = 13'h1FF0;
    localparam logic [7:0]  MODE_BIT    = 8'h80;
    localparam logic [7:0]  CTRL_RESET  = 8'hFF;
    localparam logic [7:0]  MAX_BLOCKS  = 8'd128;
    localparam logic [7:0]  BYTE_ONES   = 8'hFF;

    typedef struct packed {
        logic [1:0] func;
        logic [2:0] reg_sel;
        logic [7:0] wr_data;
        logic       double_speed;
        logic       vram_bank;
    } item_t;

    typedef struct packed {
        logic [7:0]  rd_data;
        logic        xfer_valid;
        logic [15:0] xfer_src;
        logic [12:0] xfer_dst;
        logic [7:0]  xfer_blocks;
        logic        xfer_bank;
        logic [11:0] stall_cycles;
        logic        hblank_moved;
    } result_t;

endpackage

/* src/vbd_core.sv */
// register file, latched addresses and block counter of the dma engine
// works out one result per step; depends on vbd_pkg and assert_macros.svh
`include "assert_macros.svh"

module vbd_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  vbd_pkg::item_t  item,
    input  logic            color_mode,
    output vbd_pkg::result_t result
);
    import vbd_pkg::*;

    logic [7:0]  addr_regs_reg  [NUM_ADDR_REGS];
    logic [7:0]  addr_regs_next [NUM_ADDR_REGS];
    logic [7:0]  control_reg, control_next;
    logic [7:0]  blocks_left_reg, blocks_left_next;
    logic [15:0] cur_src_reg, cur_src_next;
    logic [12:0] cur_dst_reg, cur_dst_next;
    logic        hblank_mode_reg, hblank_mode_next;

    logic [15:0] src_lat;
    logic [12:0] dst_lat;
    logic [7:0]  blocks;
    logic [15:0] src_adv;
    logic [12:0] dst_adv;
    logic [15:0] src_tick;
    logic [12:0] dst_tick;
    logic [7:0]  bl_dec;

    assign src_lat  = {addr_regs_reg[0], addr_regs_reg[1]} & SRC_MASK;
    assign dst_lat  = {addr_regs_reg[2][4:0], addr_regs_reg[3]} & DST_MASK;
    assign blocks   = {1'b0, item.wr_data[6:0]} + 8'd1;
    assign src_adv  = src_lat + {4'b0, blocks, 4'b0};
    assign dst_adv  = dst_lat + {1'b0, blocks, 4'b0};
    assign src_tick = cur_src_reg + 16'd16;
    assign dst_tick = cur_dst_reg + 13'd16;
    assign bl_dec   = blocks_left_reg - 8'd1;

    always_comb
    begin
        addr_regs_next   = addr_regs_reg;
        control_next     = control_reg;
        blocks_left_next = blocks_left_reg;
        cur_src_next     = cur_src_reg;
        cur_dst_next     = cur_dst_reg;
        hblank_mode_next = hblank_mode_reg;
        result           = '0;

        case (item.func)
            FUNC_WRITE:
            begin
                case (item.reg_sel)
                    SEL_SRC_HI, SEL_SRC_LO, SEL_DST_HI, SEL_DST_LO:
                    begin
                        addr_regs_next[item.reg_sel[1:0]] = item.wr_data;
                    end
                    SEL_CTRL:
                    begin
                        if (!color_mode)
                        begin
                            control_next = item.wr_data;
                        end
                        else if (blocks_left_reg != 8'd0)
                        begin
                            // cancel a pending transfer, a set mode bit is ignored
                            if ((item.wr_data & MODE_BIT) == 8'd0)
                            begin
                                control_next     = control_reg | MODE_BIT;
                                blocks_left_next = 8'd0;
                                hblank_mode_next = 1'b0;
                            end
                        end
                        else if ((item.wr_data & MODE_BIT) == 8'd0)
                        begin
                            // general burst: whole length at once
                            result.xfer_valid   = 1'b1;
                            result.xfer_src     = src_lat;
                            result.xfer_dst     = dst_lat;
                            result.xfer_blocks  = blocks;
                            result.xfer_bank    = item.vram_bank;
                            result.stall_cycles = item.double_speed ? {blocks, 4'b0}
                                                                    : {1'b0, blocks, 3'b0};
                            cur_src_next      = src_adv;
                            cur_dst_next      = dst_adv;
                            addr_regs_next[0] = src_adv[15:8];
                            addr_regs_next[1] = src_adv[7:0];
                            addr_regs_next[2] = {3'b0, dst_adv[12:8]};
                            addr_regs_next[3] = dst_adv[7:0];
                            blocks_left_next  = 8'd0;
                            hblank_mode_next  = 1'b0;
                            control_next      = CTRL_RESET;
                        end
                        else
                        begin
                            cur_src_next     = src_lat;
                            cur_dst_next     = dst_lat;
                            blocks_left_next = blocks;
                            hblank_mode_next = 1'b1;
                            control_next     = {1'b0, item.wr_data[6:0]};
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            FUNC_READ:
            begin
                case (item.reg_sel)
                    SEL_SRC_HI, SEL_SRC_LO, SEL_DST_HI, SEL_DST_LO:
                    begin
                        result.rd_data = addr_regs_reg[item.reg_sel[1:0]];
                    end
                    SEL_CTRL:
                    begin
                        result.rd_data = control_reg;
                    end
                    default:
                    begin
                        result.rd_data = BYTE_ONES;
                    end
                endcase
            end
            FUNC_TICK:
            begin
                if (blocks_left_reg != 8'd0)
                begin
                    result.xfer_valid   = 1'b1;
                    result.xfer_src     = cur_src_reg;
                    result.xfer_dst     = cur_dst_reg;
                    result.xfer_blocks  = 8'd1;
                    result.xfer_bank    = item.vram_bank;
                    result.hblank_moved = 1'b1;
                    cur_src_next      = src_tick;
                    cur_dst_next      = dst_tick;
                    addr_regs_next[0] = src_tick[15:8];
                    addr_regs_next[1] = src_tick[7:0];
                    addr_regs_next[2] = {3'b0, dst_tick[12:8]};
                    addr_regs_next[3] = dst_tick[7:0];
                    blocks_left_next  = bl_dec;
                    // control shows remaining minus one, all ones when done
                    control_next      = bl_dec - 8'd1;
                    if (bl_dec == 8'd0)
                    begin
                        hblank_mode_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ADDR_REGS; i++)
            begin
                addr_regs_reg[i] <= 8'd0;
            end
            control_reg     <= CTRL_RESET;
            blocks_left_reg <= 8'd0;
            cur_src_reg     <= 16'd0;
            cur_dst_reg     <= 13'd0;
            hblank_mode_reg <= 1'b0;
        end
        else if (step)
        begin
            addr_regs_reg   <= addr_regs_next;
            control_reg     <= control_next;
            blocks_left_reg <= blocks_left_next;
            cur_src_reg     <= cur_src_next;
            cur_dst_reg     <= cur_dst_next;
            hblank_mode_reg <= hblank_mode_next;
        end
    end

    `VBD_ASSERT(a_mode_tracks_count, hblank_mode_reg == (blocks_left_reg != 8'd0), "hblank mode out of step with block count")
    `VBD_ASSERT(a_count_bound, blocks_left_reg <= MAX_BLOCKS, "block count above limit")
    `VBD_ASSERT_NEXT(a_tick_decrements, step && item.func == FUNC_TICK && blocks_left_reg != 8'd0, blocks_left_reg == $past(blocks_left_reg) - 8'd1, "tick did not consume a block")

endmodule

/* src/vram_block_dma_engine.sv */
// a result is offered once its item has passed the input stage and result register,
// later while the result register waits for out_ready; input stage and result register
// run as a pipeline at one item per cycle unless out_ready holds the result register
// the result register holds a result while the next item waits in the input stage
// reset: address bytes and counters clear, control reads 0xFF, engine enabled
// configuration writes are taken in any cycle
`include "assert_macros.svh"

module vram_block_dma_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  func,
    input  logic [2:0]  reg_sel,
    input  logic [7:0]  wr_data,
    input  logic        double_speed,
    input  logic        vram_bank,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  rd_data,
    output logic        xfer_valid,
    output logic [15:0] xfer_src,
    output logic [12:0] xfer_dst,
    output logic [7:0]  xfer_blocks,
    output logic        xfer_bank,
    output logic [11:0] stall_cycles,
    output logic        hblank_moved
);
    import vbd_pkg::*;

    logic    color_mode_reg;
    logic    in_vld_reg;
    item_t   item_reg;
    logic    out_vld_reg;
    result_t res_reg;
    result_t res_next;
    logic    res_free;
    logic    step;

    assign cfg_ready = 1'b1;
    assign res_free  = !out_vld_reg || out_ready;
    assign step      = in_vld_reg && res_free;
    assign in_ready  = !in_vld_reg || res_free;

    vbd_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item_reg),
        .color_mode (color_mode_reg),
        .result     (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg <= 1'b1;
            in_vld_reg     <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                color_mode_reg <= cfg_data;
            end
            if (in_ready)
            begin
                in_vld_reg <= in_valid;
            end
            if (res_free)
            begin
                out_vld_reg <= step;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= '{func: func, reg_sel: reg_sel, wr_data: wr_data,
                          double_speed: double_speed, vram_bank: vram_bank};
        end
        if (step)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_vld_reg;
    assign rd_data      = res_reg.rd_data;
    assign xfer_valid   = res_reg.xfer_valid;
    assign xfer_src     = res_reg.xfer_src;
    assign xfer_dst     = res_reg.xfer_dst;
    assign xfer_blocks  = res_reg.xfer_blocks;
    assign xfer_bank    = res_reg.xfer_bank;
    assign stall_cycles = res_reg.stall_cycles;
    assign hblank_moved = res_reg.hblank_moved;

    `VBD_ASSERT(a_empty_stage_ready, !in_vld_reg |-> in_ready,
                "empty input stage refused a transfer")
    `VBD_ASSERT_NEXT(a_step_fills_result, step, out_vld_reg, "processed item left no result")
    `VBD_ASSERT_NEXT(a_stall_holds_item, in_vld_reg && !res_free,
                     in_vld_reg && $stable(item_reg),
                     "waiting item lost while result stalled")

endmodule

/* tb/vram_block_dma_engine_tb.sv */
`timescale 1ns / 100ps
// testbench of vram_block_dma_engine: directed and random register and tick traffic,
// results checked against an in-bench model of the dma controller
// depends on vbd_pkg and the vram_block_dma_engine rtl

module vram_block_dma_engine_tb;
    import vbd_pkg::*;

    localparam logic [1:0] FUNC_NONE     = 2'd3;
    localparam logic [2:0] SEL_LAST      = 3'd7;
    localparam int         IDLE_LIMIT    = 2000;
    localparam int         SETTLE_CYCLES = 4;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_data = 1'b1;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  func = '0;
    logic [2:0]  reg_sel = '0;
    logic [7:0]  wr_data = '0;
    logic        double_speed = 1'b0;
    logic        vram_bank = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  rd_data;
    logic        xfer_valid;
    logic [15:0] xfer_src;
    logic [12:0] xfer_dst;
    logic [7:0]  xfer_blocks;
    logic        xfer_bank;
    logic [11:0] stall_cycles;
    logic        hblank_moved;

    vram_block_dma_engine dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .reg_sel      (reg_sel),
        .wr_data      (wr_data),
        .double_speed (double_speed),
        .vram_bank    (vram_bank),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .rd_data      (rd_data),
        .xfer_valid   (xfer_valid),
        .xfer_src     (xfer_src),
        .xfer_dst     (xfer_dst),
        .xfer_blocks  (xfer_blocks),
        .xfer_bank    (xfer_bank),
        .stall_cycles (stall_cycles),
        .hblank_moved (hblank_moved)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // model state of the dma controller
    logic [7:0]  dma_addr [NUM_ADDR_REGS] = '{default: 8'h00};
    logic [7:0]  dma_ctrl = CTRL_RESET;
    logic [7:0]  blk_left = 8'd0;
    logic [15:0] src_ptr = 16'd0;
    logic [12:0] dst_ptr = 13'd0;
    logic        engine_on = 1'b1;

    item_t   bus_ops_q [$];
    result_t dma_resp_q [$];
    item_t   cur_op = '0;
    int      ops_made = 0;
    int      fail_cnt = 0;
    int      send_gap = 0;
    int      hold_cnt = 0;
    int      idle_cycles = 0;
    bit      calm = 1'b0;

    function automatic void advance_ptrs(logic [7:0] nblk);
        logic [12:0] step;
        step = {1'b0, nblk, 4'b0000};
        src_ptr = src_ptr + {3'b000, step};
        dst_ptr = (dst_ptr + step) & DST_MASK;
        dma_addr[SEL_SRC_HI] = src_ptr[15:8];
        dma_addr[SEL_SRC_LO] = src_ptr[7:0];
        dma_addr[SEL_DST_HI] = {3'b000, dst_ptr[12:8]};
        dma_addr[SEL_DST_LO] = dst_ptr[7:0];
    endfunction

    function automatic result_t dma_step(item_t op);
        result_t     r;
        logic [7:0]  nblk;
        r = '0;
        case (op.func)
            FUNC_WRITE:
            begin
                if (op.reg_sel < SEL_CTRL)
                begin
                    dma_addr[op.reg_sel[1:0]] = op.wr_data;
                end
                else if (op.reg_sel == SEL_CTRL)
                begin
                    if (!engine_on)
                    begin
                        dma_ctrl = op.wr_data;
                    end
                    else if (blk_left != 8'd0)
                    begin
                        // bit 7 clear cancels a pending hblank transfer, set is ignored
                        if ((op.wr_data & MODE_BIT) == 8'h00)
                        begin
                            dma_ctrl = dma_ctrl | MODE_BIT;
                            blk_left = 8'd0;
                        end
                    end
                    else
                    begin
                        nblk = {1'b0, op.wr_data[6:0]} + 8'd1;
                        src_ptr = {dma_addr[SEL_SRC_HI], dma_addr[SEL_SRC_LO]} & SRC_MASK;
                        dst_ptr = {dma_addr[SEL_DST_HI][4:0], dma_addr[SEL_DST_LO]} & DST_MASK;
                        if ((op.wr_data & MODE_BIT) == 8'h00)
                        begin
                            r.xfer_valid = 1'b1;
                            r.xfer_src = src_ptr;
                            r.xfer_dst = dst_ptr;
                            r.xfer_blocks = nblk;
                            r.xfer_bank = op.vram_bank;
                            r.stall_cycles = op.double_speed ? {nblk, 4'b0000}
                                                             : {1'b0, nblk, 3'b000};
                            advance_ptrs(nblk);
                            blk_left = 8'd0;
                            dma_ctrl = CTRL_RESET;
                        end
                        else
                        begin
                            blk_left = nblk;
                            dma_ctrl = nblk - 8'd1;
                        end
                    end
                end
            end
            FUNC_READ:
            begin
                if (op.reg_sel < SEL_CTRL)
                    r.rd_data = dma_addr[op.reg_sel[1:0]];
                else if (op.reg_sel == SEL_CTRL)
                    r.rd_data = dma_ctrl;
                else
                    r.rd_data = BYTE_ONES;
            end
            FUNC_TICK:
            begin
                // pending blocks move even with the engine switched off
                if (blk_left != 8'd0)
                begin
                    r.xfer_valid = 1'b1;
                    r.xfer_src = src_ptr;
                    r.xfer_dst = dst_ptr;
                    r.xfer_blocks = 8'd1;
                    r.xfer_bank = op.vram_bank;
                    r.hblank_moved = 1'b1;
                    advance_ptrs(8'd1);
                    blk_left = blk_left - 8'd1;
                    dma_ctrl = blk_left - 8'd1;
                end
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    function automatic string resp_str(result_t r);
        return $sformatf("rd=%02h xv=%b src=%04h dst=%04h blk=%0d bank=%b stall=%0d moved=%b",
                         r.rd_data, r.xfer_valid, r.xfer_src, r.xfer_dst, r.xfer_blocks,
                         r.xfer_bank, r.stall_cycles, r.hblank_moved);
    endfunction

    task automatic add_op(int f, int s, int d, int ds, int bk);
        item_t op;
        op.func = f[1:0];
        op.reg_sel = s[2:0];
        op.wr_data = d[7:0];
        op.double_speed = ds[0];
        op.vram_bank = bk[0];
        bus_ops_q.push_back(op);
        ops_made++;
    endtask

    task automatic add_rand_op(int f, int s, int d);
        add_op(f, s, d, $urandom_range(0, 1), $urandom_range(0, 1));
    endtask

    // mostly well-formed sequences: address setup, then a burst or an hblank run
    task automatic add_random_seq();
        int kind;
        int nb;
        int k;
        int pick;
        bit stop;
        kind = $urandom_range(0, 9);
        if (kind < 2)
        begin
            add_rand_op($urandom_range(FUNC_WRITE, FUNC_NONE), $urandom_range(SEL_SRC_HI, SEL_LAST),
                        $urandom_range(0, 255));
        end
        else
        begin
            for (k = SEL_SRC_HI; k <= SEL_DST_LO; k++)
                if ($urandom_range(0, 7) != 0)
                    add_rand_op(FUNC_WRITE, k, $urandom_range(0, 255));
            nb = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
            if (kind < 5)
            begin
                add_rand_op(FUNC_WRITE, SEL_CTRL, nb);
                if ($urandom_range(0, 1) != 0)
                    add_rand_op(FUNC_READ, $urandom_range(SEL_SRC_HI, SEL_CTRL), $urandom_range(0, 255));
            end
            else
            begin
                add_rand_op(FUNC_WRITE, SEL_CTRL, MODE_BIT | nb);
                k = 0;
                stop = 1'b0;
                while (k <= nb + 1 && !stop)
                begin
                    pick = $urandom_range(0, 15);
                    if (pick == 0 && k > 0)
                    begin
                        add_rand_op(FUNC_WRITE, SEL_CTRL, $urandom_range(0, 127));
                        stop = 1'b1;
                    end
                    else if (pick == 1)
                        add_rand_op(FUNC_WRITE, SEL_CTRL, MODE_BIT | $urandom_range(0, 127));
                    else if (pick < 4)
                        add_rand_op(FUNC_READ, $urandom_range(SEL_SRC_HI, SEL_LAST), $urandom_range(0, 255));
                    else if (pick == 4)
                        add_rand_op(FUNC_WRITE, $urandom_range(SEL_SRC_HI, SEL_DST_LO), $urandom_range(0, 255));
                    if (!stop)
                        add_rand_op(FUNC_TICK, $urandom_range(SEL_SRC_HI, SEL_LAST), $urandom_range(0, 255));
                    k++;
                end
            end
        end
    endtask

    // sender holds off until every queued op has produced its result
    task automatic drain();
        do
            @(negedge clk);
        while (bus_ops_q.size() != 0 || in_valid || dma_resp_q.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_mode(bit mode);
        @(posedge clk);
        cfg_data <= mode;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        engine_on = mode;
        cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int count, bit mode);
        int target;
        drain();
        write_mode(mode);
        target = ops_made + count;
        while (ops_made < target)
            add_random_seq();
    endtask

    always @(posedge clk)
    begin : drive_proc
        bit busy;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            busy = in_valid;
            if (in_valid && in_ready)
            begin
                dma_resp_q.push_back(dma_step(cur_op));
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (bus_ops_q.size() != 0)
                begin
                    cur_op = bus_ops_q.pop_front();
                    busy = 1'b1;
                    if (!calm && $urandom_range(0, 9) == 0)
                        send_gap = $urandom_range(1, 15);
                end
            end
            in_valid <= busy;
            func <= cur_op.func;
            reg_sel <= cur_op.reg_sel;
            wr_data <= cur_op.wr_data;
            double_speed <= cur_op.double_speed;
            vram_bank <= cur_op.vram_bank;
        end
    end

    always @(posedge clk)
    begin : check_proc
        result_t got;
        result_t want;
        bit rdy;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                got = {rd_data, xfer_valid, xfer_src, xfer_dst, xfer_blocks, xfer_bank,
                       stall_cycles, hblank_moved};
                if (dma_resp_q.size() == 0)
                begin
                    fail_cnt++;
                    if (fail_cnt <= 10)
                        $display("%0t: result with nothing pending: %s", $time, resp_str(got));
                end
                else
                begin
                    want = dma_resp_q.pop_front();
                    if (got !== want)
                    begin
                        fail_cnt++;
                        if (fail_cnt <= 10)
                        begin
                            $display("%0t: result mismatch", $time);
                            $display("  exp %s", resp_str(want));
                            $display("  got %s", resp_str(got));
                        end
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
                if (!calm && $urandom_range(0, 11) == 0)
                    hold_cnt = $urandom_range(1, 15);
            end
            out_ready <= rdy;
        end
    end

    // watchdog: cycles without any transfer on any channel
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("vram_block_dma_engine test failed");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reads after reset, out-of-range select, idle tick, unused func code
        add_op(FUNC_READ, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_READ, SEL_LAST, 8'hFF, 1, 1);
        add_op(FUNC_TICK, SEL_SRC_HI, 8'h00, 0, 1);
        add_op(FUNC_NONE, SEL_LAST, 8'hFF, 1, 1);
        add_op(FUNC_WRITE, SEL_CTRL + 1, 8'hAA, 0, 0);
        // longest burst from the top of both address spaces, wraps both pointers
        add_op(FUNC_WRITE, SEL_SRC_HI, 8'hFF, 0, 0);
        add_op(FUNC_WRITE, SEL_SRC_LO, 8'hFF, 0, 0);
        add_op(FUNC_WRITE, SEL_DST_HI, 8'hFF, 0, 0);
        add_op(FUNC_WRITE, SEL_DST_LO, 8'hFF, 0, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'h7F, 1, 1);
        add_op(FUNC_READ, SEL_SRC_LO, 8'h00, 0, 0);
        add_op(FUNC_READ, SEL_DST_HI, 8'h00, 0, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'h00, 0, 0);
        // hblank run: ignored rewrite, address write mid-run, cancel
        add_op(FUNC_WRITE, SEL_CTRL, 8'h82, 0, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'hFF, 0, 0);
        add_op(FUNC_TICK, SEL_CTRL, 8'h00, 1, 1);
        add_op(FUNC_WRITE, SEL_SRC_HI, 8'h12, 0, 0);
        add_op(FUNC_READ, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_READ, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_TICK, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'h81, 0, 0);
        drain();
        // engine off with blocks pending: ticks still move, control stores raw
        write_mode(1'b0);
        add_op(FUNC_TICK, SEL_SRC_HI, 8'h00, 1, 0);
        add_op(FUNC_WRITE, SEL_CTRL, 8'h05, 0, 0);
        add_op(FUNC_READ, SEL_CTRL, 8'h00, 0, 0);
        add_op(FUNC_TICK, SEL_SRC_HI, 8'h00, 0, 1);
        add_op(FUNC_READ, SEL_CTRL, 8'h00, 0, 0);

        run_random(700, 1'b1);
        run_random(300, 1'b0);
        run_random(500, 1'b1);
        run_random(200, 1'b0);
        drain();
        calm = 1'b1;
        run_random(200, 1'b1);
        drain();

        if (fail_cnt == 0)
            $display("vram_block_dma_engine test passed");
        else
            $display("vram_block_dma_engine test failed");
        $finish;
    end

endmodule

/* files.f */
+incdir+src
src/vbd_pkg.sv
src/vbd_core.sv
src/vram_block_dma_engine.sv
tb/vram_block_dma_engine_tb.sv
